// ===== sv/brfb_pkg.sv =====
// Package: constants, operation codes and transfer types of the byte ring FIFO.
package brfb_pkg;

	localparam int CAPACITY  = 256;
	localparam int MAX_BURST = 8;
	localparam int LANES     = 8;
	localparam int LANE_W    = $clog2(LANES);
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ROWS      = CAPACITY / LANES;
	localparam int ROW_W     = (IDX_W > LANE_W) ? IDX_W - LANE_W : 1;

	localparam logic [2:0] MODE_PUSH    = 3'd0;
	localparam logic [2:0] MODE_POP     = 3'd1;
	localparam logic [2:0] MODE_PEEK    = 3'd2;
	localparam logic [2:0] MODE_RESET   = 3'd3;
	localparam logic [2:0] MODE_DISCARD = 3'd4;

	localparam logic STAT_DONE     = 1'b0;
	localparam logic STAT_REJECTED = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  byte_count;
		logic [7:0]  peek_offset;
		logic [63:0] write_bytes;
	} cmd_t;

	typedef struct packed {
		logic [63:0] read_bytes;
		logic        status;
		logic [8:0]  fill_level;
		logic [8:0]  free_space;
		logic        is_empty;
	} rsp_t;

endpackage

// ===== sv/byte_ring_fifo_burst_unit.sv =====
// Top level: byte ring FIFO with burst push, pop and peek over eight banked byte memories.
//
//  channel  | signals               | transfer when
//  ---------+-----------------------+--------------------------
//  command  | start, busy, cmd      | start high, busy low
//  response | done, rsp             | done high (one cycle)
//
// Busy is high in the cycle after each accepted transfer, while the eight byte banks are
// read and written at one row each; a new command may enter while the last is in stage 2.
// Each command passes stage 1 and stage 2, and its response comes from an output register.
// arst_n clears the counters, the per-byte valid bits and the pipeline flags.
// The receiver cannot stall; every command yields exactly one response.
module byte_ring_fifo_burst_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  brfb_pkg::cmd_t  cmd,
	output logic            done,
	output brfb_pkg::rsp_t  rsp
);

	logic                        s1_vld_q;
	brfb_pkg::cmd_t              cmd_s1;
	logic [brfb_pkg::CNT_W-1:0]  wc_q;
	logic [brfb_pkg::CNT_W-1:0]  rc_q;
	logic [brfb_pkg::CAPACITY-1:0] vld_q;

	logic [brfb_pkg::CNT_W-1:0]  fill_s1;
	logic [brfb_pkg::CNT_W-1:0]  room_s1;
	logic [brfb_pkg::CNT_W-1:0]  n_s1;
	logic                        too_long_s1;
	logic                        wr_go;
	logic                        rd_go;
	logic                        pop_go;
	logic                        rej_s1;
	logic [brfb_pkg::IDX_W-1:0]  base_s1;

	logic [brfb_pkg::LANE_W-1:0] lane_i   [brfb_pkg::LANES];
	logic [brfb_pkg::IDX_W-1:0]  lane_addr[brfb_pkg::LANES];
	logic [brfb_pkg::LANES-1:0]  lane_we;
	logic [7:0]                  lane_rd  [brfb_pkg::LANES];
	logic [brfb_pkg::LANES-1:0]  lane_vld;

	logic                        s2_vld_q;
	logic                        rd_go_s2;
	logic                        rej_s2;
	logic [3:0]                  n_s2;
	logic [brfb_pkg::LANE_W-1:0] base_lo_s2;

	logic [63:0]                 rd_bytes;
	logic [brfb_pkg::CNT_W-1:0]  fill_s2;
	logic [brfb_pkg::CNT_W-1:0]  free_s2;

	assign busy = s1_vld_q;

	// decode in stage 1
	assign fill_s1     = wc_q - rc_q;
	assign room_s1     = brfb_pkg::CNT_W'(brfb_pkg::CAPACITY) - fill_s1;
	assign n_s1        = brfb_pkg::CNT_W'(cmd_s1.byte_count);
	assign too_long_s1 = cmd_s1.byte_count > 4'(brfb_pkg::MAX_BURST);

	always_comb begin
		wr_go   = 1'b0;
		rd_go   = 1'b0;
		pop_go  = 1'b0;
		rej_s1  = 1'b0;
		base_s1 = rc_q[brfb_pkg::IDX_W-1:0];
		unique case (cmd_s1.mode)
			brfb_pkg::MODE_PUSH: begin
				base_s1 = wc_q[brfb_pkg::IDX_W-1:0];
				if (too_long_s1 || n_s1 > room_s1) rej_s1 = 1'b1;
				else wr_go = 1'b1;
			end
			brfb_pkg::MODE_POP: begin
				if (too_long_s1 || n_s1 > fill_s1) rej_s1 = 1'b1;
				else begin
					rd_go  = 1'b1;
					pop_go = 1'b1;
				end
			end
			brfb_pkg::MODE_PEEK: begin
				base_s1 = rc_q[brfb_pkg::IDX_W-1:0] + brfb_pkg::IDX_W'(cmd_s1.peek_offset);
				if (too_long_s1 || n_s1 > fill_s1) rej_s1 = 1'b1;
				else rd_go = 1'b1;
			end
			brfb_pkg::MODE_RESET, brfb_pkg::MODE_DISCARD: begin
			end
			default: rej_s1 = 1'b1;
		endcase
	end

	// byte banks, interleaved by the low address bits
	for (genvar b = 0; b < brfb_pkg::LANES; b++) begin : g_bank
		logic [7:0]                 bank_mem [brfb_pkg::ROWS];
		logic [7:0]                 rd_q;
		logic                       rv_q;
		logic [brfb_pkg::ROW_W-1:0] row;

		assign lane_i[b]    = brfb_pkg::LANE_W'(b) - base_s1[brfb_pkg::LANE_W-1:0];
		assign lane_addr[b] = base_s1 + brfb_pkg::IDX_W'(lane_i[b]);
		assign row          = brfb_pkg::ROW_W'(lane_addr[b] >> brfb_pkg::LANE_W);
		assign lane_we[b]   = s1_vld_q && wr_go && (4'(lane_i[b]) < cmd_s1.byte_count);

		always_ff @(posedge clk) begin
			if (lane_we[b]) bank_mem[row] <= cmd_s1.write_bytes[8*lane_i[b] +: 8];
			rd_q <= bank_mem[row];
			rv_q <= vld_q[lane_addr[b]];
		end

		assign lane_rd[b]  = rd_q;
		assign lane_vld[b] = rv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int b = 0; b < brfb_pkg::LANES; b++) begin
				if (lane_we[b]) vld_q[lane_addr[b]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
			done     <= 1'b0;
			wc_q     <= '0;
			rc_q     <= '0;
		end else begin
			s1_vld_q <= start && !busy;
			s2_vld_q <= s1_vld_q;
			done     <= s2_vld_q;
			if (s1_vld_q) begin
				if (wr_go) wc_q <= wc_q + n_s1;
				if (pop_go) rc_q <= rc_q + n_s1;
				if (cmd_s1.mode == brfb_pkg::MODE_RESET) begin
					wc_q <= '0;
					rc_q <= '0;
				end
				if (cmd_s1.mode == brfb_pkg::MODE_DISCARD) rc_q <= wc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) cmd_s1 <= cmd;
		if (s1_vld_q) begin
			rd_go_s2   <= rd_go;
			rej_s2     <= rej_s1;
			n_s2       <= cmd_s1.byte_count;
			base_lo_s2 <= base_s1[brfb_pkg::LANE_W-1:0];
		end
	end

	// stage 2: rotate bank data into transfer order
	always_comb begin
		logic [brfb_pkg::LANE_W-1:0] ln;
		rd_bytes = '0;
		for (int i = 0; i < brfb_pkg::LANES; i++) begin
			ln = base_lo_s2 + brfb_pkg::LANE_W'(i);
			if (rd_go_s2 && 4'(i) < n_s2 && lane_vld[ln]) rd_bytes[8*i +: 8] = lane_rd[ln];
		end
	end

	assign fill_s2 = wc_q - rc_q;
	assign free_s2 = brfb_pkg::CNT_W'(brfb_pkg::CAPACITY) - fill_s2;

	always_ff @(posedge clk) begin
		if (s2_vld_q) begin
			rsp.read_bytes <= rd_bytes;
			rsp.status     <= rej_s2 ? brfb_pkg::STAT_REJECTED : brfb_pkg::STAT_DONE;
			rsp.fill_level <= 9'(fill_s2);
			rsp.free_space <= 9'(free_s2);
			rsp.is_empty   <= (wc_q == rc_q);
		end
	end

endmodule

// ===== sv/brfb_checker.sv =====
// Checker: port-level properties of the byte ring FIFO, bound to the top level.
module brfb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input brfb_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command transfer");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("response missing three cycles after command");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response strobe longer than one cycle");

	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (10'(rsp.fill_level) + 10'(rsp.free_space) == 10'(brfb_pkg::CAPACITY)))
		else $error("fill level and free space do not add up to capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.fill_level == 9'd0)))
		else $error("empty flag disagrees with fill level");

endmodule

bind byte_ring_fifo_burst_unit brfb_checker u_brfb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ===== dv/tb.sv =====
// Testbench: byte ring FIFO burst unit, command stream against an in-line ring predictor.
module tb;

	class fifo_scoreboard;
		logic [7:0]                ring [brfb_pkg::CAPACITY];
		logic [brfb_pkg::CNT_W-1:0] wr_cnt;
		logic [brfb_pkg::CNT_W-1:0] rd_cnt;
		brfb_pkg::rsp_t            expected_q [$];
		int                        errors;
		int                        n_checked;
		int                        n_rejected;
		int                        n_full;
		int                        n_empty;
		int                        n_by_mode [8];

		function new();
			foreach (ring[i]) ring[i] = '0;
			foreach (n_by_mode[i]) n_by_mode[i] = 0;
			wr_cnt     = '0;
			rd_cnt     = '0;
			errors     = 0;
			n_checked  = 0;
			n_rejected = 0;
			n_full     = 0;
			n_empty    = 0;
		endfunction

		function int pending_count();
			return expected_q.size();
		endfunction

		// predict the response of one accepted command and advance the ring state
		function void note_cmd(brfb_pkg::cmd_t c);
			brfb_pkg::rsp_t             r;
			int                         n;
			int                         fill;
			logic [brfb_pkg::CNT_W-1:0] lvl;
			logic [brfb_pkg::IDX_W-1:0] idx;
			r    = '0;
			n    = int'(c.byte_count);
			lvl  = wr_cnt - rd_cnt;
			fill = int'(lvl);
			n_by_mode[c.mode]++;
			if (c.mode <= brfb_pkg::MODE_PEEK && n > brfb_pkg::MAX_BURST) begin
				r.status = brfb_pkg::STAT_REJECTED;
			end else begin
				case (c.mode)
					brfb_pkg::MODE_PUSH: begin
						if (n > brfb_pkg::CAPACITY - fill) begin
							r.status = brfb_pkg::STAT_REJECTED;
						end else begin
							for (int i = 0; i < n; i++) begin
								idx = brfb_pkg::IDX_W'(int'(wr_cnt) + i);
								ring[idx] = c.write_bytes[8*i +: 8];
							end
							wr_cnt = brfb_pkg::CNT_W'(int'(wr_cnt) + n);
						end
					end
					brfb_pkg::MODE_POP: begin
						if (n > fill) begin
							r.status = brfb_pkg::STAT_REJECTED;
						end else begin
							for (int i = 0; i < n; i++) begin
								idx = brfb_pkg::IDX_W'(int'(rd_cnt) + i);
								r.read_bytes[8*i +: 8] = ring[idx];
							end
							rd_cnt = brfb_pkg::CNT_W'(int'(rd_cnt) + n);
						end
					end
					brfb_pkg::MODE_PEEK: begin
						if (n > fill) begin
							r.status = brfb_pkg::STAT_REJECTED;
						end else begin
							for (int i = 0; i < n; i++) begin
								idx = brfb_pkg::IDX_W'(int'(rd_cnt) + int'(c.peek_offset) + i);
								r.read_bytes[8*i +: 8] = ring[idx];
							end
						end
					end
					brfb_pkg::MODE_RESET: begin
						wr_cnt = '0;
						rd_cnt = '0;
					end
					brfb_pkg::MODE_DISCARD: begin
						rd_cnt = wr_cnt;
					end
					default: begin
						r.status = brfb_pkg::STAT_REJECTED;
					end
				endcase
			end
			lvl          = wr_cnt - rd_cnt;
			r.fill_level = lvl;
			r.free_space = 9'(brfb_pkg::CAPACITY - int'(lvl));
			r.is_empty   = (wr_cnt == rd_cnt);
			if (r.status == brfb_pkg::STAT_REJECTED) n_rejected++;
			if (int'(lvl) == brfb_pkg::CAPACITY) n_full++;
			if (r.is_empty) n_empty++;
			expected_q.push_back(r);
		endfunction

		function void check_rsp(brfb_pkg::rsp_t got);
			brfb_pkg::rsp_t exp;
			if (expected_q.size() == 0) begin
				$error("response with no command outstanding");
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			n_checked++;
			if (got.read_bytes !== exp.read_bytes) begin
				$error("read_bytes: expected %h, got %h", exp.read_bytes, got.read_bytes);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.fill_level !== exp.fill_level) begin
				$error("fill_level: expected %0d, got %0d", exp.fill_level, got.fill_level);
				errors++;
			end
			if (got.free_space !== exp.free_space) begin
				$error("free_space: expected %0d, got %0d", exp.free_space, got.free_space);
				errors++;
			end
			if (got.is_empty !== exp.is_empty) begin
				$error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	brfb_pkg::cmd_t cmd;
	logic           done;
	brfb_pkg::rsp_t rsp;

	fifo_scoreboard sb = new();
	int idle_pct = 0;
	int n_sent   = 0;

	byte_ring_fifo_burst_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_rsp(rsp);
			if (start && !busy) sb.note_cmd(cmd);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic brfb_pkg::cmd_t mk(logic [2:0] m, int n, int off, logic [63:0] data);
		brfb_pkg::cmd_t c;
		c.mode        = m;
		c.byte_count  = 4'(n);
		c.peek_offset = 8'(off);
		c.write_bytes = data;
		return c;
	endfunction

	task automatic send(brfb_pkg::cmd_t c);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	task automatic run_phase(int pct, int quota);
		int stop_at;
		int k;
		stop_at  = n_sent + quota;
		idle_pct = pct;
		while (n_sent < stop_at) begin
			k = $urandom_range(10, 60);
			case ($urandom_range(9))
				0, 1, 2: begin
					repeat (k) send(mk(brfb_pkg::MODE_PUSH, $urandom_range(1, 8),
						$urandom_range(255), rand64()));
				end
				3, 4, 5: begin
					repeat (k) begin
						if ($urandom_range(3) == 0)
							send(mk(brfb_pkg::MODE_PEEK, $urandom_range(8), $urandom_range(255),
								rand64()));
						else
							send(mk(brfb_pkg::MODE_POP, $urandom_range(1, 8), $urandom_range(255),
								rand64()));
					end
				end
				6, 7: begin
					repeat (k) send(mk(3'($urandom_range(2)), $urandom_range(8),
						$urandom_range(255), rand64()));
				end
				8: begin
					repeat (k / 3) send(mk(3'($urandom_range(7)), $urandom_range(15),
						$urandom_range(255), rand64()));
				end
				default: begin
					send(mk($urandom_range(1) ? brfb_pkg::MODE_RESET : brfb_pkg::MODE_DISCARD,
						$urandom_range(15), $urandom_range(255), rand64()));
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero-length, empty, extremes, overlong bursts, peek wrap, unknown modes
		send(mk(brfb_pkg::MODE_PUSH, 0, 0, '1));
		send(mk(brfb_pkg::MODE_POP, 0, 0, '1));
		send(mk(brfb_pkg::MODE_PEEK, 0, 255, '1));
		send(mk(brfb_pkg::MODE_POP, 1, 0, '0));
		send(mk(brfb_pkg::MODE_PEEK, 1, 0, '0));
		send(mk(brfb_pkg::MODE_PUSH, 8, 0, '1));
		send(mk(brfb_pkg::MODE_PUSH, 8, 255, '0));
		send(mk(brfb_pkg::MODE_PUSH, 3, 0, 64'h0123_4567_89ab_cdef));
		send(mk(brfb_pkg::MODE_PUSH, 15, 0, '1));
		send(mk(brfb_pkg::MODE_POP, 9, 0, '1));
		send(mk(brfb_pkg::MODE_PEEK, 12, 0, '1));
		send(mk(brfb_pkg::MODE_PEEK, 8, 0, '0));
		send(mk(brfb_pkg::MODE_PEEK, 8, 255, '0));
		send(mk(brfb_pkg::MODE_PEEK, 8, 17, '0));
		send(mk(brfb_pkg::MODE_POP, 8, 0, '0));
		send(mk(brfb_pkg::MODE_POP, 5, 0, '0));
		send(mk(3'd5, 8, 0, '1));
		send(mk(3'd6, 0, 0, '0));
		send(mk(3'd7, 15, 255, '1));
		send(mk(brfb_pkg::MODE_DISCARD, 15, 255, '1));
		send(mk(brfb_pkg::MODE_PUSH, 4, 0, 64'hfedc_ba98_7654_3210));
		send(mk(brfb_pkg::MODE_RESET, 15, 255, '1));
		send(mk(brfb_pkg::MODE_POP, 1, 0, '0));
		send(mk(brfb_pkg::MODE_PUSH, 8, 0, 64'ha5a5_5a5a_c3c3_3c3c));
		drain();

		run_phase(0, 325);
		drain();
		run_phase(71, 325);
		drain();
		run_phase(35, 325);
		drain();
		run_phase(0, 325);

		drain();
		repeat (10) @(posedge clk);
		$display("%0d transfers checked: %0d push, %0d pop, %0d peek, %0d reset, %0d discard",
			sb.n_checked, sb.n_by_mode[brfb_pkg::MODE_PUSH], sb.n_by_mode[brfb_pkg::MODE_POP],
			sb.n_by_mode[brfb_pkg::MODE_PEEK], sb.n_by_mode[brfb_pkg::MODE_RESET],
			sb.n_by_mode[brfb_pkg::MODE_DISCARD]);
		$display("%0d rejected, ring full %0d times, empty %0d times",
			sb.n_rejected, sb.n_full, sb.n_empty);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

endmodule
